[design/point_triangle_sq_distance_defines.svh]
// Assertion macros shared by the point-to-triangle distance RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef POINT_TRIANGLE_SQ_DISTANCE_DEFINES_SVH
`define POINT_TRIANGLE_SQ_DISTANCE_DEFINES_SVH
`ifndef ASSERT_OFF
`define PTSD_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("ptsd: same-cycle check failed");
`define PTSD_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("ptsd: next-cycle check failed");
`else
`define PTSD_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define PTSD_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif
`endif

[design/ptsd_pkg.sv]
// Shared widths, constants and types for the point-to-triangle distance pipeline.
// No dependencies.
package ptsd_pkg;

  localparam int COORD_BITS = 24;
  localparam int EW   = COORD_BITS + 1;
  localparam int PRW  = 2 * EW;
  localparam int DW   = PRW + 2;
  localparam int SMW  = DW + 2;
  localparam int HW   = DW / 2;
  localparam int PPW  = 2 * HW + 2;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int QW   = NW + 1;
  localparam int FRAC = 32;
  localparam int SW   = FRAC + 1;
  localparam int CW   = EW + SW + 1;
  localparam int MW   = CW - 1;
  localparam int ML   = MW / 2;
  localparam int MH   = MW - ML;
  localparam int SQW  = 2 * MW;
  localparam int OW   = 53;
  localparam int RSH  = 2 * FRAC;
  localparam int XW   = (SQW + 2 > RSH + OW + 1) ? SQW + 2 : RSH + OW + 1;

  localparam logic [SW-1:0] ONE_FX   = {1'b1, {FRAC{1'b0}}};
  localparam logic [OW-1:0] DIST_MAX = {OW{1'b1}};

  typedef logic [2:0][EW-1:0] vec3_t;

  typedef struct packed {
    vec3_t e0;
    vec3_t e1;
    vec3_t v;
  } geom_t;

  typedef struct packed {
    geom_t geom;
    logic  s_comp;
    logic  t_comp;
    logic  degen;
  } side_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [NW-1:0] den;
  } div_req_t;

  typedef enum logic [1:0] {
    Q_ZERO,
    Q_ONE,
    Q_ITER
  } qkind_t;

  typedef struct packed {
    qkind_t          kind;
    logic [QW-1:0]   rem;
    logic [QW-1:0]   den;
    logic [FRAC-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [PPW-1:0] hh;
    logic [PPW-1:0] hl;
    logic [PPW-1:0] lh;
    logic [PPW-1:0] ll;
  } part_t;

  typedef struct packed {
    logic [DW-1:0]  a;
    logic [DW-1:0]  c;
    logic [SMW-1:0] nd;
    logic [SMW-1:0] ne;
    logic [SMW-1:0] ns;
    logic [SMW-1:0] nt;
    logic [SMW-1:0] dn;
  } lin_t;

endpackage

[design/ptsd_front.sv]
// Front pipeline: edge vectors, dot products, split wide products, region choice.
// Depends on ptsd_pkg; feeds two quotient requests and a side record to ptsd_div.
module ptsd_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_vld,
  input  logic [2:0][ptsd_pkg::COORD_BITS-1:0] pa,
  input  logic [2:0][ptsd_pkg::COORD_BITS-1:0] pb,
  input  logic [2:0][ptsd_pkg::COORD_BITS-1:0] pc,
  input  logic [2:0][ptsd_pkg::COORD_BITS-1:0] pq,
  output logic                                  vld_o,
  output ptsd_pkg::div_req_t                    req_s,
  output ptsd_pkg::div_req_t                    req_t,
  output ptsd_pkg::side_t                       side_o
);
  import ptsd_pkg::*;

  function automatic part_t split_mul(logic [DW-1:0] x, logic [DW-1:0] y);
    logic signed [HW:0] xh;
    logic signed [HW:0] xl;
    logic signed [HW:0] yh;
    logic signed [HW:0] yl;
    part_t r;
    xh = $signed(x[DW-1:HW]);
    xl = $signed({1'b0, x[HW-1:0]});
    yh = $signed(y[DW-1:HW]);
    yl = $signed({1'b0, y[HW-1:0]});
    r.hh = xh * yh;
    r.hl = xh * yl;
    r.lh = xl * yh;
    r.ll = xl * yl;
    return r;
  endfunction

  function automatic logic [PW-1:0] join_mul(part_t p);
    logic signed [PW-1:0] hh;
    logic signed [PW-1:0] hl;
    logic signed [PW-1:0] lh;
    logic signed [PW-1:0] ll;
    hh = PW'($signed(p.hh));
    hl = PW'($signed(p.hl));
    lh = PW'($signed(p.lh));
    ll = PW'($signed(p.ll));
    return (hh <<< (2 * HW)) + ((hl + lh) <<< HW) + ll;
  endfunction

  logic [6:0]            vld_r;
  geom_t                 g_nxt;
  geom_t                 g_r [6];
  logic signed [PRW-1:0] p_nxt [5][3];
  logic signed [PRW-1:0] p_r [5][3];
  logic signed [DW-1:0]  dot_nxt [5];
  logic signed [DW-1:0]  dot_r [5];
  part_t                 pp_nxt [6];
  part_t                 pp_r [6];
  lin_t                  lin_nxt;
  lin_t                  lin_r [3];
  logic signed [PW-1:0]  prod_nxt [6];
  logic signed [PW-1:0]  prod_r [6];
  logic signed [NW-1:0]  det_nxt, sn_nxt, tn_nxt;
  logic signed [NW-1:0]  det_r, sn_r, tn_r;
  div_req_t              rs_nxt, rt_nxt, rs_r, rt_r;
  side_t                 side_nxt, side_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g_nxt.e0[k] = EW'($signed(pb[k])) - EW'($signed(pa[k]));
      g_nxt.e1[k] = EW'($signed(pc[k])) - EW'($signed(pa[k]));
      g_nxt.v[k]  = EW'($signed(pa[k])) - EW'($signed(pq[k]));
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_nxt[0][k] = $signed(g_r[0].e0[k]) * $signed(g_r[0].e0[k]);
      p_nxt[1][k] = $signed(g_r[0].e0[k]) * $signed(g_r[0].e1[k]);
      p_nxt[2][k] = $signed(g_r[0].e1[k]) * $signed(g_r[0].e1[k]);
      p_nxt[3][k] = $signed(g_r[0].e0[k]) * $signed(g_r[0].v[k]);
      p_nxt[4][k] = $signed(g_r[0].e1[k]) * $signed(g_r[0].v[k]);
    end
  end

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      dot_nxt[j] = DW'(p_r[j][0]) + DW'(p_r[j][1]) + DW'(p_r[j][2]);
    end
  end

  // Dot products: 0 = e0.e0, 1 = e0.e1, 2 = e1.e1, 3 = e0.v, 4 = e1.v.
  always_comb begin
    pp_nxt[0] = split_mul(dot_r[0], dot_r[2]);
    pp_nxt[1] = split_mul(dot_r[1], dot_r[1]);
    pp_nxt[2] = split_mul(dot_r[1], dot_r[4]);
    pp_nxt[3] = split_mul(dot_r[2], dot_r[3]);
    pp_nxt[4] = split_mul(dot_r[1], dot_r[3]);
    pp_nxt[5] = split_mul(dot_r[0], dot_r[4]);
    lin_nxt.a  = dot_r[0];
    lin_nxt.c  = dot_r[2];
    lin_nxt.nd = -(SMW'(dot_r[3]));
    lin_nxt.ne = -(SMW'(dot_r[4]));
    lin_nxt.ns = SMW'(dot_r[2]) + SMW'(dot_r[4]) - SMW'(dot_r[1]) - SMW'(dot_r[3]);
    lin_nxt.nt = SMW'(dot_r[0]) + SMW'(dot_r[3]) - SMW'(dot_r[1]) - SMW'(dot_r[4]);
    lin_nxt.dn = SMW'(dot_r[0]) - (SMW'(dot_r[1]) <<< 1) + SMW'(dot_r[2]);
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      prod_nxt[i] = join_mul(pp_r[i]);
    end
  end

  always_comb begin
    det_nxt = NW'(prod_r[0]) - NW'(prod_r[1]);
    sn_nxt  = NW'(prod_r[2]) - NW'(prod_r[3]);
    tn_nxt  = NW'(prod_r[4]) - NW'(prod_r[5]);
  end

  always_comb begin
    logic signed [NW:0] sum;
    logic               in_tri;
    logic               sneg;
    logic               tneg;
    logic               d_neg;
    logic               ns_pos;
    logic               nt_pos;
    div_req_t           zr;
    div_req_t           qa;
    div_req_t           qc;
    div_req_t           qe;
    div_req_t           qf;
    sum    = (NW + 1)'(sn_r) + (NW + 1)'(tn_r);
    in_tri = sum < (NW + 1)'(det_r);
    sneg   = sn_r[NW-1];
    tneg   = tn_r[NW-1];
    d_neg  = $signed(lin_r[2].nd) > 0;
    ns_pos = $signed(lin_r[2].ns) > 0;
    nt_pos = $signed(lin_r[2].nt) > 0;
    zr     = '0;
    qa.num = NW'($signed(lin_r[2].nd));
    qa.den = NW'($signed(lin_r[2].a));
    qc.num = NW'($signed(lin_r[2].ne));
    qc.den = NW'($signed(lin_r[2].c));
    qe.num = NW'($signed(lin_r[2].ns));
    qe.den = NW'($signed(lin_r[2].dn));
    qf.num = NW'($signed(lin_r[2].nt));
    qf.den = NW'($signed(lin_r[2].dn));
    rs_nxt = zr;
    rt_nxt = zr;
    side_nxt.geom   = g_r[5];
    side_nxt.s_comp = 1'b0;
    side_nxt.t_comp = 1'b0;
    side_nxt.degen  = (det_r == '0);
    if (in_tri) begin
      priority if (sneg) begin
        if (tneg && d_neg) begin
          rs_nxt = qa;
        end else begin
          rt_nxt = qc;
        end
      end else if (tneg) begin
        rs_nxt = qa;
      end else begin
        rs_nxt.num = sn_r;
        rs_nxt.den = det_r;
        rt_nxt.num = tn_r;
        rt_nxt.den = det_r;
      end
    end else begin
      priority if (sneg) begin
        if (ns_pos) begin
          rs_nxt          = qe;
          side_nxt.t_comp = 1'b1;
        end else begin
          rt_nxt = qc;
        end
      end else if (tneg) begin
        if (nt_pos) begin
          rt_nxt          = qf;
          side_nxt.s_comp = 1'b1;
        end else begin
          rs_nxt = qa;
        end
      end else begin
        rs_nxt          = qe;
        side_nxt.t_comp = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r[0] <= g_nxt;
      for (int i = 1; i < 6; i++) begin
        g_r[i] <= g_r[i-1];
      end
      p_r      <= p_nxt;
      dot_r    <= dot_nxt;
      pp_r     <= pp_nxt;
      lin_r[0] <= lin_nxt;
      lin_r[1] <= lin_r[0];
      lin_r[2] <= lin_r[1];
      prod_r   <= prod_nxt;
      det_r    <= det_nxt;
      sn_r     <= sn_nxt;
      tn_r     <= tn_nxt;
      rs_r     <= rs_nxt;
      rt_r     <= rt_nxt;
      side_r   <= side_nxt;
    end
  end

  assign vld_o  = vld_r[6];
  assign req_s  = rs_r;
  assign req_t  = rt_r;
  assign side_o = side_r;

endmodule

[design/ptsd_div.sv]
// Pipelined restoring divider: two clamped quotients, one quotient bit per stage.
// Depends on ptsd_pkg and the assertion macros; feeds ptsd_back.
`include "point_triangle_sq_distance_defines.svh"
module ptsd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         vld_i,
  input  ptsd_pkg::div_req_t           req_s,
  input  ptsd_pkg::div_req_t           req_t,
  input  ptsd_pkg::side_t              side_i,
  output logic                         vld_o,
  output logic [ptsd_pkg::SW-1:0]      qs,
  output logic [ptsd_pkg::SW-1:0]      qt,
  output ptsd_pkg::side_t              side_o
);
  import ptsd_pkg::*;

  function automatic div_lane_t div_start(div_req_t r);
    div_lane_t l;
    l.rem = {1'b0, r.num};
    l.den = {1'b0, r.den};
    l.quo = '0;
    priority if ($signed(r.den) <= 0 || $signed(r.num) <= 0) begin
      l.kind = Q_ZERO;
    end else if ($signed(r.num) >= $signed(r.den)) begin
      l.kind = Q_ONE;
    end else begin
      l.kind = Q_ITER;
    end
    return l;
  endfunction

  function automatic div_lane_t div_step(div_lane_t x);
    logic [QW-1:0] r2;
    div_lane_t     y;
    r2 = x.rem << 1;
    y  = x;
    if (x.kind == Q_ITER) begin
      if (r2 >= x.den) begin
        y.rem = r2 - x.den;
        y.quo = {x.quo[FRAC-2:0], 1'b1};
      end else begin
        y.rem = r2;
        y.quo = {x.quo[FRAC-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  function automatic logic [SW-1:0] div_value(div_lane_t x);
    logic [SW-1:0] q;
    unique case (x.kind)
      Q_ZERO:  q = '0;
      Q_ONE:   q = ONE_FX;
      Q_ITER:  q = {1'b0, x.quo};
      default: q = '0;
    endcase
    return q;
  endfunction

  logic [FRAC:0]  vld_r;
  div_lane_t      ls_r [FRAC+1];
  div_lane_t      lt_r [FRAC+1];
  side_t          sd_r [FRAC+1];
  logic           vo_r;
  logic [SW-1:0]  qs_r, qt_r;
  side_t          so_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vo_r  <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[FRAC-1:0], vld_i};
      vo_r  <= vld_r[FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ls_r[0] <= div_start(req_s);
      lt_r[0] <= div_start(req_t);
      sd_r[0] <= side_i;
      for (int i = 1; i <= FRAC; i++) begin
        ls_r[i] <= div_step(ls_r[i-1]);
        lt_r[i] <= div_step(lt_r[i-1]);
        sd_r[i] <= sd_r[i-1];
      end
      qs_r <= div_value(ls_r[FRAC]);
      qt_r <= div_value(lt_r[FRAC]);
      so_r <= sd_r[FRAC];
    end
  end

  assign vld_o  = vo_r;
  assign qs     = qs_r;
  assign qt     = qt_r;
  assign side_o = so_r;

  `PTSD_ASSERT_IMPL(a_qs_range, clk, rst_n, vo_r, qs_r <= ONE_FX)
  `PTSD_ASSERT_IMPL(a_qt_range, clk, rst_n, vo_r, qt_r <= ONE_FX)

endmodule

[design/ptsd_back.sv]
// Back pipeline: closest-point offset, split squaring, sum, rounding and saturation.
// Depends on ptsd_pkg and the assertion macros; drives the result beat.
`include "point_triangle_sq_distance_defines.svh"
module ptsd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     vld_i,
  input  logic [ptsd_pkg::SW-1:0]  qs,
  input  logic [ptsd_pkg::SW-1:0]  qt,
  input  ptsd_pkg::side_t          side_i,
  output logic                     out_vld,
  output logic [ptsd_pkg::OW-1:0]  out_dist,
  output logic                     out_degen
);
  import ptsd_pkg::*;

  logic [7:0]            vld_r;
  logic [6:0]            dg_r;
  logic [SW-1:0]         s_nxt, t_nxt, s_r, t_r;
  geom_t                 gx_r;
  vec3_t                 vv_r;
  logic signed [CW-1:0]  ps_nxt [3];
  logic signed [CW-1:0]  pt_nxt [3];
  logic signed [CW-1:0]  ps_r [3];
  logic signed [CW-1:0]  pt_r [3];
  logic signed [CW-1:0]  comp_nxt [3];
  logic signed [CW-1:0]  comp_r [3];
  logic [MW-1:0]         mag_nxt [3];
  logic [MW-1:0]         mag_r [3];
  logic [2*MH-1:0]       hh_nxt [3];
  logic [2*MH-1:0]       hh_r [3];
  logic [MW-1:0]         hl_nxt [3];
  logic [MW-1:0]         hl_r [3];
  logic [2*ML-1:0]       ll_nxt [3];
  logic [2*ML-1:0]       ll_r [3];
  logic [SQW-1:0]        sq_nxt [3];
  logic [SQW-1:0]        sq_r [3];
  logic [XW-1:0]         acc_nxt, acc_r;
  logic [OW-1:0]         dist_nxt, dist_r;
  logic                  deg_r;

  always_comb begin
    s_nxt = side_i.s_comp ? ONE_FX - qt : qs;
    t_nxt = side_i.t_comp ? ONE_FX - qs : qt;
  end

  always_comb begin
    logic signed [SW:0] s_sg;
    logic signed [SW:0] t_sg;
    s_sg = $signed({1'b0, s_r});
    t_sg = $signed({1'b0, t_r});
    for (int k = 0; k < 3; k++) begin
      ps_nxt[k] = s_sg * $signed(gx_r.e0[k]);
      pt_nxt[k] = t_sg * $signed(gx_r.e1[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      comp_nxt[k] = (CW'($signed(vv_r[k])) <<< FRAC) + ps_r[k] + pt_r[k];
      mag_nxt[k]  = comp_r[k][CW-1] ? MW'(-comp_r[k]) : MW'(comp_r[k]);
      hh_nxt[k]   = mag_r[k][MW-1:ML] * mag_r[k][MW-1:ML];
      hl_nxt[k]   = mag_r[k][MW-1:ML] * mag_r[k][ML-1:0];
      ll_nxt[k]   = mag_r[k][ML-1:0] * mag_r[k][ML-1:0];
      sq_nxt[k]   = (SQW'(hh_r[k]) << (2 * ML)) + (SQW'(hl_r[k]) << (ML + 1))
                    + SQW'(ll_r[k]);
    end
  end

  always_comb begin
    logic sat;
    acc_nxt  = XW'(sq_r[0]) + XW'(sq_r[1]) + XW'(sq_r[2]) + (XW'(1) << (RSH - 1));
    sat      = |acc_r[XW-1:RSH+OW];
    dist_nxt = sat ? DIST_MAX : acc_r[RSH+OW-1:RSH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[6:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r    <= s_nxt;
      t_r    <= t_nxt;
      gx_r   <= side_i.geom;
      dg_r   <= {dg_r[5:0], side_i.degen};
      vv_r   <= gx_r.v;
      ps_r   <= ps_nxt;
      pt_r   <= pt_nxt;
      comp_r <= comp_nxt;
      mag_r  <= mag_nxt;
      hh_r   <= hh_nxt;
      hl_r   <= hl_nxt;
      ll_r   <= ll_nxt;
      sq_r   <= sq_nxt;
      acc_r  <= acc_nxt;
      dist_r <= dist_nxt;
      deg_r  <= dg_r[6];
    end
  end

  assign out_vld   = vld_r[7];
  assign out_dist  = dist_r;
  assign out_degen = deg_r;

  `PTSD_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(vld_r))

endmodule

[design/point_triangle_sq_distance.sv]
// Point-to-triangle squared distance, top level with valid/ready beats.
// Depends on ptsd_pkg, ptsd_front, ptsd_div, ptsd_back and the assertion macros.
//
// Takes one beat of three triangle corners and a query point per cycle while
// in_ready is high and returns one beat per input beat, in order. The 34-stage
// restoring divider (a set-up stage, 32 quotient-bit stages and an output stage)
// forms the two clamped barycentric parameters; seven front stages build the dot
// products and wide determinants, and eight back stages square, sum, round and
// saturate. The whole pipeline advances together whenever the output register is
// empty or its beat is taken, so a stalled result holds every stage and nothing
// is lost.
`include "point_triangle_sq_distance_defines.svh"
module point_triangle_sq_distance (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_corner_a_x,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_corner_a_y,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_corner_a_z,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_corner_b_x,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_corner_b_y,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_corner_b_z,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_corner_c_x,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_corner_c_y,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_corner_c_z,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_query_x,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_query_y,
  input  logic signed [ptsd_pkg::COORD_BITS-1:0] in_query_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ptsd_pkg::OW-1:0]               out_squared_distance,
  output logic                                  out_degenerate
);
  import ptsd_pkg::*;

  logic          adv;
  logic          f_vld, d_vld;
  div_req_t      req_s, req_t;
  side_t         f_side, d_side;
  logic [SW-1:0] qs, qt;

  assign adv      = out_ready | ~out_valid;
  assign in_ready = adv;

  ptsd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .pa     ({in_corner_a_z, in_corner_a_y, in_corner_a_x}),
    .pb     ({in_corner_b_z, in_corner_b_y, in_corner_b_x}),
    .pc     ({in_corner_c_z, in_corner_c_y, in_corner_c_x}),
    .pq     ({in_query_z, in_query_y, in_query_x}),
    .vld_o  (f_vld),
    .req_s  (req_s),
    .req_t  (req_t),
    .side_o (f_side)
  );

  ptsd_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (f_vld),
    .req_s  (req_s),
    .req_t  (req_t),
    .side_i (f_side),
    .vld_o  (d_vld),
    .qs     (qs),
    .qt     (qt),
    .side_o (d_side)
  );

  ptsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .vld_i     (d_vld),
    .qs        (qs),
    .qt        (qt),
    .side_i    (d_side),
    .out_vld   (out_valid),
    .out_dist  (out_squared_distance),
    .out_degen (out_degenerate)
  );

  `PTSD_ASSERT_IMPL(a_reset_empty, clk, rst_n, $past(!rst_n), !out_valid)

endmodule
